FILE: hdl/cbfm_pkg.sv
// ----------------------------------------------------------------------------
// cbfm_pkg: shared types and codes of the clock buffer frame manager
// Request modes, status codes, the sequencer state type and the pending
// result word.
// ----------------------------------------------------------------------------
package cbfm_pkg;

   // request modes
   localparam logic [2:0] MODE_READ    = 3'd0;
   localparam logic [2:0] MODE_ALLOC   = 3'd1;
   localparam logic [2:0] MODE_UNPIN   = 3'd2;
   localparam logic [2:0] MODE_DISPOSE = 3'd3;
   localparam logic [2:0] MODE_FLUSH   = 3'd4;

   // result status codes
   localparam logic [2:0] STS_OK         = 3'd0;
   localparam logic [2:0] STS_ALL_PINNED = 3'd1;
   localparam logic [2:0] STS_NOT_PINNED = 3'd2;
   localparam logic [2:0] STS_PINNED     = 3'd3;
   localparam logic [2:0] STS_NOT_FOUND  = 3'd4;

   // most result words one flush may produce
   localparam int unsigned OUT_MAX = 16;
   localparam int unsigned CNT_W   = 5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LK_RD,
      ST_LK_EV,
      ST_SW_RD,
      ST_SW_EV,
      ST_FL_RD,
      ST_FL_EV,
      ST_DONE
   } state_type;

   // result word without its frame index
   typedef struct packed {
      logic [2:0]  status;
      logic        hit;
      logic        fetch;
      logic        wb;
      logic [7:0]  wb_file;
      logic [31:0] wb_page;
      logic        del;
   } res_type;

endpackage

FILE: hdl/clock_buffer_frame_manager.sv
// ----------------------------------------------------------------------------
// clock_buffer_frame_manager: frame table of a page buffer pool
// Tag lookup, clock (second-chance) replacement, unpin, dispose and flush.
// ----------------------------------------------------------------------------
// Usage:
//   req_* takes one request word (mode, file id, page number, dirty mark).
//   rsp_* returns one or more result words; rsp_tlast marks the final word
//   of a request. Only flush gives more than one word (one per written-back
//   frame, up to 16).
// Timing: one request at a time; req_tready is high only while idle.
//   Every frame visit is a RAM read, then an evaluate and write-back step,
//   so the frame entry RAM port sets the pace:
//   hit:    the lookup ends at the matching frame
//   miss:   the lookup visits every frame, then the clock hand steps on
//   flush:  the frames are walked in order, held by receiver stalls
// Reset: all frames invalid, clock hand at the last frame, no result held.
//   Tags need no clearing; a frame is only looked at when its valid bit is set.
// Stall: a result sits in the output register until rsp_tready; a flush
//   holds its walk while the previous word has not left.
// ----------------------------------------------------------------------------
module clock_buffer_frame_manager #(
   parameter int unsigned NUM_FRAMES = 16,
   parameter int unsigned PIN_BITS   = 8,
   localparam int unsigned FRAME_BITS = $clog2(NUM_FRAMES),
   localparam int unsigned RSP_W      = ((FRAME_BITS + 47 + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   // tdata: mode[2:0], file_id[10:3], page[42:11], mark_dirty[43], zero
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [47:0]      req_tdata,
   // tdata: frame_index, status, was_hit, fetch_needed, writeback_needed,
   //        writeback_file, writeback_page, delete_page, zero fill
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata,
   output logic             rsp_tlast
);
   import cbfm_pkg::*;

   localparam int unsigned ENT_W   = PIN_BITS + 42;
   localparam int unsigned PCNT_W  = $clog2(NUM_FRAMES + 1);
   localparam logic [FRAME_BITS-1:0] LAST_FRAME = FRAME_BITS'(NUM_FRAMES - 1);
   localparam logic [PIN_BITS-1:0]   PIN_MAX    = '1;

   state_type             state_ff, state_in;
   logic [FRAME_BITS-1:0] idx_ff, idx_in;
   logic [FRAME_BITS-1:0] hand_ff, hand_in;
   logic [PCNT_W-1:0]     pinned_ff, pinned_in;
   logic [CNT_W-1:0]      n_ff, n_in;
   logic [NUM_FRAMES-1:0] valid_ff, valid_in;
   logic [2:0]            mode_ff, mode_in;
   logic [7:0]            file_ff, file_in;
   logic [31:0]           page_ff, page_in;
   logic                  md_ff, md_in;
   res_type               hold_ff, hold_in;
   logic [FRAME_BITS-1:0] hold_frame_ff, hold_frame_in;
   res_type               out_ff, out_in;
   logic [FRAME_BITS-1:0] out_frame_ff, out_frame_in;
   logic                  out_last_ff, out_last_in;
   logic                  rsp_tvalid_ff, rsp_tvalid_in;

   // frame entry RAM: {referenced, dirty, pins, file tag, page tag}
   logic                  ram_wr_en, ram_rd_en;
   logic [FRAME_BITS-1:0] ram_wr_addr, ram_rd_addr;
   logic [ENT_W-1:0]      ram_wr_data, ram_rd_data;

   cbfm_ram #(.WIDTH(ENT_W), .DEPTH(NUM_FRAMES)) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   logic                e_ref, e_dirty;
   logic [PIN_BITS-1:0] e_pins;
   logic [7:0]          e_file;
   logic [31:0]         e_page;
   logic                out_free;
   logic                hit, match, produce, final_word, stop;
   res_type             new_res;

   assign e_ref    = ram_rd_data[ENT_W-1];
   assign e_dirty  = ram_rd_data[ENT_W-2];
   assign e_pins   = ram_rd_data[ENT_W-3 -: PIN_BITS];
   assign e_file   = ram_rd_data[39:32];
   assign e_page   = ram_rd_data[31:0];
   assign out_free = !rsp_tvalid_ff || rsp_tready;

   // sequencer: reads never share a cycle with a write, so no forwarding
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      hand_in       = hand_ff;
      pinned_in     = pinned_ff;
      n_in          = n_ff;
      valid_in      = valid_ff;
      mode_in       = mode_ff;
      file_in       = file_ff;
      page_in       = page_ff;
      md_in         = md_ff;
      hold_in       = hold_ff;
      hold_frame_in = hold_frame_ff;
      out_in        = out_ff;
      out_frame_in  = out_frame_ff;
      out_last_in   = out_last_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = idx_ff;
      ram_wr_data   = ram_rd_data;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = idx_ff;
      hit           = valid_ff[idx_ff] && e_file == file_ff && e_page == page_ff;
      match         = valid_ff[idx_ff] && e_file == file_ff;
      produce       = 1'b0;
      final_word    = 1'b0;
      stop          = 1'b0;
      new_res       = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               mode_in       = req_tdata[2:0];
               file_in       = req_tdata[10:3];
               page_in       = req_tdata[42:11];
               md_in         = req_tdata[43];
               hold_in       = '0;
               hold_frame_in = '0;
               n_in          = '0;
               idx_in        = '0;
               pinned_in     = '0;
               if (req_tdata[2:0] == MODE_FLUSH) begin
                  state_in = ST_FL_RD;
               end else if (req_tdata[2:0] == MODE_READ || req_tdata[2:0] == MODE_ALLOC ||
                            req_tdata[2:0] == MODE_UNPIN ||
                            req_tdata[2:0] == MODE_DISPOSE) begin
                  state_in = ST_LK_RD;
               end else begin
                  hold_in.status = STS_NOT_FOUND;
                  state_in       = ST_DONE;
               end
            end
         end

         ST_LK_RD: begin
            ram_rd_en = 1'b1;
            state_in  = ST_LK_EV;
         end

         // compare one frame's tag
         ST_LK_EV: begin
            if (hit) begin
               hold_frame_in = idx_ff;
               hold_in.hit   = 1'b1;
               state_in      = ST_DONE;
               if (mode_ff == MODE_UNPIN) begin
                  if (e_pins == '0) begin
                     hold_in.status = STS_NOT_PINNED;
                  end else begin
                     ram_wr_en   = 1'b1;
                     ram_wr_data = {e_ref, e_dirty | md_ff, e_pins - 1'b1, e_file, e_page};
                  end
               end else if (mode_ff == MODE_DISPOSE) begin
                  hold_in.wb      = e_dirty;
                  hold_in.wb_file = e_dirty ? e_file : 8'd0;
                  hold_in.wb_page = e_dirty ? e_page : 32'd0;
                  hold_in.del     = 1'b1;
                  valid_in[idx_ff] = 1'b0;
               end else begin
                  ram_wr_en   = 1'b1;
                  ram_wr_data = {1'b1, e_dirty,
                                 (e_pins == PIN_MAX) ? e_pins : e_pins + 1'b1,
                                 e_file, e_page};
               end
            end else if (idx_ff == LAST_FRAME) begin
               if (mode_ff == MODE_UNPIN || mode_ff == MODE_DISPOSE) begin
                  hold_in.status = STS_NOT_FOUND;
                  state_in       = ST_DONE;
               end else begin
                  state_in = ST_SW_RD;
               end
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_LK_RD;
            end
         end

         // advance the clock hand and read its frame
         ST_SW_RD: begin
            hand_in     = (hand_ff == LAST_FRAME) ? '0 : hand_ff + 1'b1;
            ram_rd_en   = 1'b1;
            ram_rd_addr = hand_in;
            state_in    = ST_SW_EV;
         end

         ST_SW_EV: begin
            ram_wr_addr = hand_ff;
            if (!valid_ff[hand_ff] || (!e_ref && e_pins == '0)) begin
               if (valid_ff[hand_ff] && e_dirty) begin
                  hold_in.wb      = 1'b1;
                  hold_in.wb_file = e_file;
                  hold_in.wb_page = e_page;
               end
               ram_wr_en         = 1'b1;
               ram_wr_data       = {1'b1, 1'b0, PIN_BITS'(1), file_ff, page_ff};
               valid_in[hand_ff] = 1'b1;
               hold_frame_in     = hand_ff;
               hold_in.fetch     = (mode_ff == MODE_READ);
               state_in          = ST_DONE;
            end else if (e_ref) begin
               ram_wr_en   = 1'b1;
               ram_wr_data = {1'b0, e_dirty, e_pins, e_file, e_page};
               state_in    = ST_SW_RD;
            end else if (pinned_ff == PCNT_W'(NUM_FRAMES - 1)) begin
               hold_in.status = STS_ALL_PINNED;
               state_in       = ST_DONE;
            end else begin
               pinned_in = pinned_ff + 1'b1;
               state_in  = ST_SW_RD;
            end
         end

         ST_FL_RD: begin
            ram_rd_en = 1'b1;
            state_in  = ST_FL_EV;
         end

         // flush walk: one frame per visit, pending word held until the next
         ST_FL_EV: begin
            new_res.wb_file = e_file;
            new_res.wb_page = e_page;
            if (match) begin
               if (e_pins != '0) begin
                  if (n_ff == CNT_W'(OUT_MAX)) begin
                     stop = 1'b1;
                  end else begin
                     produce         = 1'b1;
                     final_word      = 1'b1;
                     new_res         = '0;
                     new_res.status  = STS_PINNED;
                  end
               end else if (e_dirty) begin
                  if (n_ff == CNT_W'(OUT_MAX)) begin
                     stop = 1'b1;
                  end else begin
                     produce    = 1'b1;
                     new_res.wb = 1'b1;
                  end
               end
            end
            if (!(produce && n_ff != '0 && !out_free)) begin
               if (produce) begin
                  if (n_ff != '0) begin
                     out_in        = hold_ff;
                     out_frame_in  = hold_frame_ff;
                     out_last_in   = 1'b0;
                     rsp_tvalid_in = 1'b1;
                  end
                  hold_in       = produce ? new_res : hold_ff;
                  hold_frame_in = idx_ff;
                  n_in          = n_ff + 1'b1;
               end
               if (match && !stop && !final_word) begin
                  valid_in[idx_ff] = 1'b0;
               end
               if (stop || final_word || idx_ff == LAST_FRAME) begin
                  state_in = ST_DONE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = ST_FL_RD;
               end
            end
         end

         // final word of the request
         ST_DONE: begin
            if (out_free) begin
               out_in        = hold_ff;
               out_frame_in  = hold_frame_ff;
               out_last_in   = 1'b1;
               rsp_tvalid_in = 1'b1;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         valid_ff      <= '0;
         hand_ff       <= LAST_FRAME;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         hand_ff       <= hand_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // payload and counters
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      pinned_ff     <= pinned_in;
      n_ff          <= n_in;
      mode_ff       <= mode_in;
      file_ff       <= file_in;
      page_ff       <= page_in;
      md_ff         <= md_in;
      hold_ff       <= hold_in;
      hold_frame_ff <= hold_frame_in;
      out_ff        <= out_in;
      out_frame_ff  <= out_frame_in;
      out_last_ff   <= out_last_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = RSP_W'({out_ff.del, out_ff.wb_page, out_ff.wb_file, out_ff.wb,
                               out_ff.fetch, out_ff.hit, out_ff.status, out_frame_ff});

endmodule

FILE: hdl/cbfm_ram.sv
// ----------------------------------------------------------------------------
// cbfm_ram: generic single-write, single-read RAM
// Registered read; read data holds when no read is issued.
// ----------------------------------------------------------------------------
module cbfm_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/cbfm_checker.sv
// ----------------------------------------------------------------------------
// cbfm_checker: port-level checks of the clock buffer frame manager
// Watches the request and result channels; bound to the top level.
// ----------------------------------------------------------------------------
module cbfm_checker #(
   parameter int unsigned FRAME_BITS = 4,
   parameter int unsigned RSP_W      = 56
) (
   input logic             clock,
   input logic             reset,
   input logic             req_tvalid,
   input logic             req_tready,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata,
   input logic             rsp_tlast
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result word changed while stalled");

   // no result right after reset
   a_rsp_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid after reset");

   // one request at a time
   a_one_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   // a non-final word on show means the request is still running
   a_mid_flush: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("request taken inside a multi-word result");

   // status codes stay in range
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[FRAME_BITS+2:FRAME_BITS] <= 3'd4)
      else $error("status code out of range");

endmodule

bind clock_buffer_frame_manager cbfm_checker #(
   .FRAME_BITS (FRAME_BITS),
   .RSP_W      (RSP_W)
) u_cbfm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

FILE: dv/clock_buffer_frame_manager_tb.sv
// ----------------------------------------------------------------------------
// clock_buffer_frame_manager_tb: self-checking bench of the frame manager
// Directed requests cover hits, misses, write-backs, unpin and dispose
// errors, unknown modes, the all-pinned case, pin saturation and flush.
// A random phase follows. Each accepted result word is checked against a
// local model of the frame table. Both sides idle at random.
// ----------------------------------------------------------------------------
module clock_buffer_frame_manager_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import cbfm_pkg::*;

   localparam int NFRAMES   = 16;
   localparam int PIN_LIMIT = 255;
   localparam int MAX_CYC   = 2000000;

   typedef struct packed {
      logic [3:0]  frame;
      logic [2:0]  status;
      logic        hit;
      logic        fetch;
      logic        wb;
      logic [7:0]  wb_file;
      logic [31:0] wb_page;
      logic        del;
      logic        last;
   } outcome_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;
   logic        rsp_tlast;

   // frame table copy
   bit          tbl_valid [NFRAMES];
   bit          tbl_ref   [NFRAMES];
   bit          tbl_dirty [NFRAMES];
   int          tbl_pins  [NFRAMES];
   logic [7:0]  tbl_file  [NFRAMES];
   logic [31:0] tbl_page  [NFRAMES];
   int          hand = NFRAMES - 1;

   outcome_type pending_words [$];
   int          mismatches = 0;
   int          cycles = 0;
   bit          calm = 1'b0;

   clock_buffer_frame_manager DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast)
   );

   always #5 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > MAX_CYC) begin
         $display("status: fail");
         $finish;
      end
   end

   function automatic int idle_draw();
      if (calm) return 0;
      return $urandom_range(0, 9);
   endfunction

   function automatic int find_tag(logic [7:0] f, logic [31:0] p);
      for (int i = 0; i < NFRAMES; i++)
         if (tbl_valid[i] && tbl_file[i] == f && tbl_page[i] == p) return i;
      return -1;
   endfunction

   function automatic void drop_frame(int i);
      tbl_valid[i] = 0;
      tbl_ref[i]   = 0;
      tbl_dirty[i] = 0;
      tbl_pins[i]  = 0;
   endfunction

   // second-chance sweep, -1 when every frame is pinned
   function automatic int pick_victim();
      int pinned = 0;
      int h;
      while (pinned < NFRAMES) begin
         hand = (hand + 1) % NFRAMES;
         h = hand;
         if (!tbl_valid[h]) return h;
         if (tbl_ref[h]) begin
            tbl_ref[h] = 0;
            continue;
         end
         if (tbl_pins[h] != 0) begin
            pinned++;
            continue;
         end
         return h;
      end
      return -1;
   endfunction

   // expected result words of one request
   function automatic void predict_words(logic [2:0] mode, logic [7:0] f,
                                         logic [31:0] p, logic md);
      outcome_type r;
      int fr;
      int n = 0;
      r = '0;
      r.last = 1;
      if (mode == MODE_READ || mode == MODE_ALLOC) begin
         fr = find_tag(f, p);
         if (fr >= 0) begin
            tbl_ref[fr] = 1;
            if (tbl_pins[fr] < PIN_LIMIT) tbl_pins[fr]++;
            r.frame = 4'(fr);
            r.hit = 1;
         end else begin
            fr = pick_victim();
            if (fr < 0) begin
               r.status = STS_ALL_PINNED;
            end else begin
               if (tbl_valid[fr] && tbl_dirty[fr]) begin
                  r.wb = 1;
                  r.wb_file = tbl_file[fr];
                  r.wb_page = tbl_page[fr];
               end
               tbl_valid[fr] = 1;
               tbl_ref[fr]   = 1;
               tbl_dirty[fr] = 0;
               tbl_pins[fr]  = 1;
               tbl_file[fr]  = f;
               tbl_page[fr]  = p;
               r.frame = 4'(fr);
               r.fetch = (mode == MODE_READ);
            end
         end
         pending_words.push_back(r);
      end else if (mode == MODE_UNPIN) begin
         fr = find_tag(f, p);
         if (fr < 0) begin
            r.status = STS_NOT_FOUND;
         end else begin
            r.frame = 4'(fr);
            r.hit = 1;
            if (tbl_pins[fr] == 0) begin
               r.status = STS_NOT_PINNED;
            end else begin
               tbl_pins[fr]--;
               if (md) tbl_dirty[fr] = 1;
            end
         end
         pending_words.push_back(r);
      end else if (mode == MODE_DISPOSE) begin
         fr = find_tag(f, p);
         if (fr < 0) begin
            r.status = STS_NOT_FOUND;
         end else begin
            r.frame = 4'(fr);
            r.hit = 1;
            if (tbl_dirty[fr]) begin
               r.wb = 1;
               r.wb_file = tbl_file[fr];
               r.wb_page = tbl_page[fr];
            end
            drop_frame(fr);
            r.del = 1;
         end
         pending_words.push_back(r);
      end else if (mode == MODE_FLUSH) begin
         for (int i = 0; i < NFRAMES; i++) begin
            if (!tbl_valid[i] || tbl_file[i] != f) continue;
            if (tbl_pins[i] > 0) begin
               if (n == OUT_MAX) break;
               r = '0;
               r.frame = 4'(i);
               r.status = STS_PINNED;
               r.last = 1;
               pending_words.push_back(r);
               return;
            end
            if (tbl_dirty[i]) begin
               if (n == OUT_MAX) break;
               r = '0;
               r.frame = 4'(i);
               r.wb = 1;
               r.wb_file = tbl_file[i];
               r.wb_page = tbl_page[i];
               pending_words.push_back(r);
               n++;
            end
            drop_frame(i);
         end
         if (n == 0) begin
            r = '0;
            r.last = 1;
            pending_words.push_back(r);
         end else begin
            pending_words[pending_words.size() - 1].last = 1;
         end
      end else begin
         r.status = STS_NOT_FOUND;
         pending_words.push_back(r);
      end
   endfunction

   // send one request word; tvalid stays up when no gap follows
   task automatic send_word(logic [2:0] mode, logic [7:0] f, logic [31:0] p,
                            logic md);
      int gap;
      gap = idle_draw();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, md, p, f, mode};
      do @(negedge clock); while (!req_tready);
      predict_words(mode, f, p, md);
      @(posedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
   endtask

   // result side: random stalls, check at the accepting edge
   initial begin
      outcome_type e;
      outcome_type a;
      int w;
      @(negedge reset);
      forever begin
         @(posedge clock);
         w = idle_draw();
         if (w > 0) begin
            rsp_tready <= 1'b0;
            repeat (w) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(negedge clock); while (!rsp_tvalid);
         a.frame   = rsp_tdata[3:0];
         a.status  = rsp_tdata[6:4];
         a.hit     = rsp_tdata[7];
         a.fetch   = rsp_tdata[8];
         a.wb      = rsp_tdata[9];
         a.wb_file = rsp_tdata[17:10];
         a.wb_page = rsp_tdata[49:18];
         a.del     = rsp_tdata[50];
         a.last    = rsp_tlast;
         if (pending_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result word %p", a);
         end else begin
            e = pending_words.pop_front();
            if (e !== a) begin
               mismatches++;
               if (mismatches <= 10) $display("mismatch exp %p act %p", e, a);
            end
         end
      end
   end

   // hits, misses, write-backs, errors, unknown modes, flush
   task automatic test_basic_ops();
      send_word(MODE_READ, 8'd0, 32'd0, 1'b0);
      send_word(MODE_ALLOC, 8'd255, 32'hFFFF_FFFF, 1'b0);
      send_word(MODE_READ, 8'd0, 32'd0, 1'b0);
      send_word(MODE_ALLOC, 8'd255, 32'hFFFF_FFFF, 1'b0);
      send_word(MODE_UNPIN, 8'd0, 32'd0, 1'b1);
      send_word(MODE_UNPIN, 8'd0, 32'd0, 1'b0);
      send_word(MODE_UNPIN, 8'd0, 32'd0, 1'b1);
      send_word(MODE_UNPIN, 8'd7, 32'd5, 1'b1);
      send_word(MODE_DISPOSE, 8'd0, 32'd0, 1'b0);
      send_word(MODE_DISPOSE, 8'd0, 32'd0, 1'b0);
      send_word(3'd5, 8'hAA, 32'h5555_AAAA, 1'b1);
      send_word(3'd6, 8'd1, 32'd1, 1'b0);
      send_word(3'd7, 8'd2, 32'd2, 1'b1);
      send_word(MODE_READ, 8'd255, 32'd1, 1'b0);
      send_word(MODE_UNPIN, 8'd255, 32'd1, 1'b1);
      send_word(MODE_UNPIN, 8'd255, 32'hFFFF_FFFF, 1'b1);
      send_word(MODE_UNPIN, 8'd255, 32'hFFFF_FFFF, 1'b1);
      send_word(MODE_FLUSH, 8'd255, 32'd0, 1'b0);
      send_word(MODE_FLUSH, 8'd255, 32'd0, 1'b0);
      drain();
   endtask

   // fill every frame pinned, miss, flush a pinned file, then clean up
   task automatic test_all_pinned();
      for (int i = 0; i < NFRAMES; i++) send_word(MODE_READ, 8'd3, i, 1'b0);
      send_word(MODE_READ, 8'd3, 32'd100, 1'b0);
      send_word(MODE_FLUSH, 8'd3, 32'd0, 1'b0);
      for (int i = 0; i < NFRAMES; i++) send_word(MODE_UNPIN, 8'd3, i, 1'b1);
      send_word(MODE_READ, 8'd4, 32'd9, 1'b0);
      send_word(MODE_FLUSH, 8'd3, 32'd0, 1'b0);
      send_word(MODE_DISPOSE, 8'd4, 32'd9, 1'b0);
      drain();
   endtask

   // pin count stops at its maximum
   task automatic test_pin_saturation();
      calm = 1'b1;
      for (int i = 0; i < PIN_LIMIT + 3; i++)
         send_word(MODE_READ, 8'd9, 32'h8000_0001, 1'b0);
      calm = 1'b0;
      for (int i = 0; i < PIN_LIMIT + 1; i += 64)
         send_word(MODE_UNPIN, 8'd9, 32'h8000_0001, 1'b1);
      send_word(MODE_DISPOSE, 8'd9, 32'h8000_0001, 1'b0);
      drain();
   endtask

   // random traffic over a small tag pool so hits and evictions are common
   task automatic test_random_traffic();
      int sel;
      logic [2:0]  mode;
      logic [7:0]  f;
      logic [31:0] p;
      for (int k = 0; k < 100; k++) begin
         if (k % 40 == 0) calm = ~calm;
         if (k % 97 == 50) drain();
         sel = $urandom_range(0, 99);
         if (sel < 35) mode = MODE_READ;
         else if (sel < 48) mode = MODE_ALLOC;
         else if (sel < 80) mode = MODE_UNPIN;
         else if (sel < 88) mode = MODE_DISPOSE;
         else if (sel < 95) mode = MODE_FLUSH;
         else mode = 3'($urandom_range(5, 7));
         f = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255))
                                          : 8'($urandom_range(0, 3));
         sel = $urandom_range(0, 19);
         if (sel == 0) p = $urandom;
         else if (sel == 1) p = 32'hFFFF_FFFF;
         else p = $urandom_range(0, 9);
         send_word(mode, f, p, 1'($urandom_range(0, 1)));
      end
      drain();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_basic_ops();
      test_all_pinned();
      test_pin_saturation();
      test_random_traffic();
      repeat (60) @(posedge clock);
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
